[rtl/core/adagrad_pkg.sv]
// Shared constants, register codes and sideband types for the Adagrad update unit.
`default_nettype none
package adagrad_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int DATA_W = 32;
	localparam int FACT_W = 16;
	localparam int NUM_W  = 48;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LR  = 2'd0,
		CFG_EPS = 2'd1,
		CFG_WD  = 2'd2
	} cfg_reg_t;

	localparam logic [FACT_W-1:0] LR_RST  = 16'd655;
	localparam logic [FACT_W-1:0] EPS_RST = 16'd1;
	localparam logic [FACT_W-1:0] WD_RST  = 16'd0;

	// carried alongside the root pipeline
	typedef struct packed {
		logic signed [DATA_W-1:0] w;
		logic [NUM_W-1:0]         num;
		logic                     neg;
		logic                     sat;
		logic [DATA_W-1:0]        acc;
	} sqrt_side_t;

	// carried alongside the divider pipeline
	typedef struct packed {
		logic signed [DATA_W-1:0] w;
		logic                     neg;
		logic                     sat;
		logic [DATA_W-1:0]        acc;
		logic                     dzero;
	} div_side_t;

endpackage
`default_nettype wire

[rtl/core/adagrad_param_update_unit.sv]
// Top level: Adagrad element update, decay/square front end, root and divide pipelines.
//
//  port group | dir | beat contents
//  s_*        | in  | gradient, weight, accum
//  m_*        | out | new_weight, new_accum, saturated
//  cfg_*      | in  | register index, write data
//
// One element per cycle sustained while the output is not stalled; the pipeline holds
// RW = (33 + FRAC_BITS) / 2 root stages and NW = 48 + max(FRAC_BITS - 16, 0)
// divide stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module adagrad_param_update_unit #(
	parameter int FRAC_BITS = adagrad_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // gradient[31:0], weight[63:32], accum[95:64]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // new_weight[31:0], new_accum[63:32], saturated[64]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [adagrad_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [adagrad_pkg::FACT_W-1:0]    cfg_data
);
	import adagrad_pkg::*;

	localparam int RW  = (DATA_W + FRAC_BITS + 1) / 2;
	localparam int DW  = ((RW > FACT_W) ? RW : FACT_W) + 1;
	localparam int LSH = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int NW  = NUM_W + LSH;
	localparam int DDW = DW + RSH;
	localparam int SQW = 2 * DATA_W;

	localparam logic signed [NW+1:0] S_MAX = (NW+2)'($signed(32'h7FFFFFFF));
	localparam logic signed [NW+1:0] S_MIN = (NW+2)'($signed(32'h80000000));
	localparam logic [SQW:0] HALF_LSB = (SQW+1)'(1) << (FRAC_BITS - 1);
	localparam logic [SQW:0] ACC_MAX  = (SQW+1)'(32'hFFFFFFFF);

	logic adv;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// configuration registers
	logic [FACT_W-1:0] lr_q, eps_q, wd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RST;
			eps_q <= EPS_RST;
			wd_q  <= WD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LR:  lr_q  <= cfg_data;
				CFG_EPS: eps_q <= cfg_data;
				CFG_WD:  wd_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: decay product
	logic                     vld_s1;
	logic signed [DATA_W-1:0] g_s1, w_s1;
	logic [DATA_W-1:0]        acc_s1;
	logic signed [48:0]       prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1    <= $signed(s_tdata[31:0]);
			w_s1    <= $signed(s_tdata[63:32]);
			acc_s1  <= s_tdata[95:64];
			prod_s1 <= $signed({1'b0, wd_q}) * $signed(s_tdata[63:32]);
		end
	end

	// stage 2: effective gradient, clipped
	logic signed [48:0] rnd;
	logic signed [33:0] gsum;
	logic               gclip_hi, gclip_lo;
	logic signed [DATA_W-1:0] g2;

	assign rnd      = prod_s1 + 49'sd32768;
	assign gsum     = 34'(g_s1) + 34'($signed(rnd[48:16]));
	assign gclip_hi = !gsum[33] && (gsum[32:31] != 2'b00);
	assign gclip_lo = gsum[33] && (gsum[32:31] != 2'b11);
	assign g2 = gclip_hi ? $signed(32'h7FFFFFFF) :
	            gclip_lo ? $signed(32'h80000000) : gsum[31:0];

	logic                     vld_s2;
	logic signed [DATA_W-1:0] w_s2;
	logic [DATA_W-1:0]        acc_s2, mag_s2;
	logic                     neg_s2, sat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2   <= w_s1;
			acc_s2 <= acc_s1;
			neg_s2 <= g2[31];
			mag_s2 <= g2[31] ? 32'(-g2) : 32'(g2);
			sat_s2 <= gclip_hi || gclip_lo;
		end
	end

	// stage 3: square and numerator
	logic                     vld_s3;
	logic signed [DATA_W-1:0] w_s3;
	logic [DATA_W-1:0]        acc_s3;
	logic [SQW-1:0]           msq_s3;
	logic [NUM_W-1:0]         num_s3;
	logic                     neg_s3, sat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3   <= w_s2;
			acc_s3 <= acc_s2;
			msq_s3 <= SQW'(mag_s2) * SQW'(mag_s2);
			num_s3 <= NUM_W'(mag_s2) * NUM_W'(lr_q);
			neg_s3 <= neg_s2;
			sat_s3 <= sat_s2;
		end
	end

	// stage 4: accumulate with saturation
	logic [SQW:0] sq, acc_sum;
	logic         acc_ovf;
	assign sq      = ({1'b0, msq_s3} + HALF_LSB) >> FRAC_BITS;
	assign acc_sum = (SQW+1)'(acc_s3) + sq;
	assign acc_ovf = acc_sum > ACC_MAX;

	logic       vld_s4;
	sqrt_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.w   <= w_s3;
			side_s4.num <= num_s3;
			side_s4.neg <= neg_s3;
			side_s4.sat <= sat_s3 || acc_ovf;
			side_s4.acc <= acc_ovf ? 32'hFFFFFFFF : acc_sum[31:0];
		end
	end

	// root of the accumulator in data format
	logic [2*RW-1:0] rad;
	assign rad = (2*RW)'(side_s4.acc) << FRAC_BITS;

	logic            sq_vld;
	logic [RW-1:0]   sq_root;
	sqrt_side_t      sq_side;

	adagrad_sqrt #(
		.RW   (RW),
		.SB_W ($bits(sqrt_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vin      (vld_s4),
		.rad      (rad),
		.side_in  (side_s4),
		.vout     (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// stage 5: denominator
	logic [DW-1:0] den;
	assign den = DW'(sq_root) + DW'(eps_q);

	logic             vld_s5;
	logic [NW-1:0]    n_s5;
	logic [DDW-1:0]   d_s5;
	div_side_t        side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s5          <= NW'(sq_side.num) << LSH;
			d_s5          <= DDW'(den) << RSH;
			side_s5.w     <= sq_side.w;
			side_s5.neg   <= sq_side.neg;
			side_s5.sat   <= sq_side.sat;
			side_s5.acc   <= sq_side.acc;
			side_s5.dzero <= den == '0;
		end
	end

	logic          dv_vld;
	logic [NW-1:0] dv_q;
	div_side_t     dv_side;

	adagrad_div #(
		.NW   (NW),
		.DDW  (DDW),
		.SB_W ($bits(div_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vin      (vld_s5),
		.dividend (n_s5),
		.divisor  (d_s5),
		.side_in  (side_s5),
		.vout     (dv_vld),
		.quot     (dv_q),
		.side_out (dv_side)
	);

	// final stage: apply step, clip, output register
	logic [NW-1:0]          step;
	logic signed [NW+1:0]   ws, nw_full;
	logic                   nclip_hi, nclip_lo;
	logic [DATA_W-1:0]      nw;

	assign step     = dv_side.dzero ? '0 : dv_q;
	assign ws       = (NW+2)'(dv_side.w);
	assign nw_full  = dv_side.neg ? ws + $signed({2'b00, step}) : ws - $signed({2'b00, step});
	assign nclip_hi = nw_full > S_MAX;
	assign nclip_lo = nw_full < S_MIN;
	assign nw = nclip_hi ? 32'h7FFFFFFF : nclip_lo ? 32'h80000000 : nw_full[31:0];

	logic [DATA_W-1:0] nw_s6, acc_s6;
	logic              sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nw_s6  <= nw;
			acc_s6 <= dv_side.acc;
			sat_s6 <= dv_side.sat || nclip_hi || nclip_lo;
		end
	end

	assign m_tdata = {7'b0, sat_s6, acc_s6, nw_s6};

`ifndef SYNTHESIS
	// root is the floor square root of the scaled accumulator
	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld |-> (64'(sq_root) * 64'(sq_root) <= (64'(sq_side.acc) << FRAC_BITS)))
		else $error("root too large");
	a_root_high: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld |-> ((64'(sq_root) + 64'd1) * (64'(sq_root) + 64'd1) >
		            (64'(sq_side.acc) << FRAC_BITS)))
		else $error("root too small");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s5) && $stable(dv_vld))
		else $error("pipeline moved while frozen");
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld && dv_side.dzero) |-> (step == '0))
		else $error("step taken on zero denominator");
`endif

endmodule
`default_nettype wire

[rtl/core/adagrad_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module adagrad_sqrt #(
	parameter int RW   = 24,
	parameter int SB_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vin,
	input  wire logic [2*RW-1:0]   rad,
	input  wire logic [SB_W-1:0]   side_in,
	output logic                   vout,
	output logic [RW-1:0]          root,
	output logic [SB_W-1:0]        side_out
);
	import adagrad_pkg::*;

	localparam int RMW = RW + 2;

	logic [RMW-1:0]  rem_s  [RW];
	logic [RW-1:0]   res_s  [RW];
	logic [2*RW-1:0] v_s    [RW];
	logic [SB_W-1:0] side_s [RW];
	logic            vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RMW-1:0]  rem_p;
		logic [RW-1:0]   res_p;
		logic [2*RW-1:0] v_p;
		logic [SB_W-1:0] side_p;
		logic            vld_p;
		logic [RMW+1:0]  rem_sh;
		logic [RMW+1:0]  trial;
		logic [RMW+1:0]  diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign res_p  = '0;
			assign v_p    = rad;
			assign side_p = side_in;
			assign vld_p  = vin;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign res_p  = res_s[k-1];
			assign v_p    = v_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign rem_sh = {rem_p, v_p[2*RW-1 -: 2]};
		assign trial  = {2'b00, res_p, 2'b01};
		assign ge     = rem_sh >= trial;
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[RMW-1:0] : rem_sh[RMW-1:0];
				res_s[k]  <= {res_p[RW-2:0], ge};
				v_s[k]    <= v_p << 2;
				side_s[k] <= side_p;
			end
		end
	end

	assign vout     = vld_s[RW-1];
	assign root     = res_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule
`default_nettype wire

[rtl/core/adagrad_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module adagrad_div #(
	parameter int NW   = 48,
	parameter int DDW  = 25,
	parameter int SB_W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire logic [NW-1:0]   dividend,
	input  wire logic [DDW-1:0]  divisor,
	input  wire logic [SB_W-1:0] side_in,
	output logic                 vout,
	output logic [NW-1:0]        quot,
	output logic [SB_W-1:0]      side_out
);
	import adagrad_pkg::*;

	logic [DDW-1:0]  rem_s  [NW];
	logic [NW-1:0]   q_s    [NW];
	logic [NW-1:0]   n_s    [NW];
	logic [DDW-1:0]  d_s    [NW];
	logic [SB_W-1:0] side_s [NW];
	logic            vld_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DDW-1:0]  rem_p;
		logic [NW-1:0]   q_p;
		logic [NW-1:0]   n_p;
		logic [DDW-1:0]  d_p;
		logic [SB_W-1:0] side_p;
		logic            vld_p;
		logic [DDW:0]    t;
		logic [DDW:0]    diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign q_p    = '0;
			assign n_p    = dividend;
			assign d_p    = divisor;
			assign side_p = side_in;
			assign vld_p  = vin;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign q_p    = q_s[k-1];
			assign n_p    = n_s[k-1];
			assign d_p    = d_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign t    = {rem_p, n_p[NW-1]};
		assign ge   = t >= {1'b0, d_p};
		assign diff = t - {1'b0, d_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DDW-1:0] : t[DDW-1:0];
				q_s[k]    <= {q_p[NW-2:0], ge};
				n_s[k]    <= n_p << 1;
				d_s[k]    <= d_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign vout     = vld_s[NW-1];
	assign quot     = q_s[NW-1];
	assign side_out = side_s[NW-1];

endmodule
`default_nettype wire
